[src/i2c_lcd_backpack_writer_defines.svh]
// Assertion macros for the I2C LCD backpack writer.
// Included by i2lcd_seq, which has the concurrent checks; no other dependencies.
`ifndef I2C_LCD_BACKPACK_WRITER_DEFINES_SVH
`define I2C_LCD_BACKPACK_WRITER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define I2LCD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("i2lcd check failed");
// next-cycle implication, checked out of reset
`define I2LCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("i2lcd check failed");
`else
`define I2LCD_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define I2LCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[src/i2lcd_pkg.sv]
// Shared types, constants and the expander byte formatter for the LCD writer.
// No dependencies.
package i2lcd_pkg;

    localparam logic [6:0] DEV_ADDR_RESET = 7'h27;
    localparam logic       BACKLIGHT_RESET = 1'b1;

    localparam logic [7:0] RS_MASK       = 8'h01;
    localparam logic [7:0] ENABLE_BIT    = 8'h04;
    localparam logic [7:0] BACKLIGHT_BIT = 8'h08;
    localparam logic [7:0] NIBBLE_MASK   = 8'hf0;

    localparam logic [2:0] EXP_LAST      = 3'd5;
    localparam logic [2:0] EXP_HI_EN     = 3'd1;
    localparam logic [2:0] EXP_LO_FIRST  = 3'd3;
    localparam logic [2:0] EXP_LO_EN     = 3'd4;
    localparam logic [2:0] BIT_LAST      = 3'd7;

    localparam logic [1:0] CFG_IDX_ADDR  = 2'd0;
    localparam logic [1:0] CFG_IDX_BL    = 2'd1;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SUBMIT = 1'b1;

    typedef struct packed {
        logic [6:0] device_address;
        logic       backlight_on;
    } cfg_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] lcd_value;
        logic       is_char;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic done_res;
        logic nack;
        logic accepted;
        logic busy_res;
        logic sda_low;
        logic scl_low;
    } res_t;

    function automatic logic [7:0] expander_byte(input logic [7:0] value,
                                                 input logic       mode,
                                                 input logic       backlight,
                                                 input logic [2:0] idx);
        logic [7:0] b;
        if (idx < EXP_LO_FIRST) begin
            b = value & NIBBLE_MASK;
        end else begin
            b = {value[3:0], 4'h0};
        end
        b = b | ({7'd0, mode} & RS_MASK);
        if (backlight) begin
            b = b | BACKLIGHT_BIT;
        end
        if (idx == EXP_HI_EN || idx == EXP_LO_EN) begin
            b = b | ENABLE_BIT;
        end
        return b;
    endfunction

endpackage

[src/i2c_lcd_backpack_writer.sv]
// Top level: stream handshake, configuration registers and result register.
// Depends on i2lcd_pkg and i2lcd_seq.
// Latency: a result appears in the cycle after its item is accepted.
// One item per cycle while m_tready allows; the result register is the only stage.
// An I2C write of one expander byte takes 59 tick items; one LCD byte takes six.
// Reset (aresetn low, synchronous): idle, both lines released, address 0x27,
// backlight on, no result pending.
module i2c_lcd_backpack_writer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // lcd_value[7:0], sda_in[8], zero pad
    input  logic [1:0]  s_tuser,   // req_type[0], is_char[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // scl_low, sda_low, busy_res, accepted, nack, done_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    i2lcd_pkg::cfg_t cfg_reg;
    i2lcd_pkg::req_t req;
    i2lcd_pkg::res_t res;
    logic            step_en;
    logic            m_valid_reg;
    logic [5:0]      m_data_reg;

    assign s_tready  = !m_valid_reg || m_tready;
    assign step_en   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign req.req_type  = s_tuser[0];
    assign req.is_char   = s_tuser[1];
    assign req.lcd_value = s_tdata[7:0];
    assign req.sda_in    = s_tdata[8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= i2lcd_pkg::DEV_ADDR_RESET;
            cfg_reg.backlight_on   <= i2lcd_pkg::BACKLIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                i2lcd_pkg::CFG_IDX_ADDR: cfg_reg.device_address <= cfg_data;
                i2lcd_pkg::CFG_IDX_BL:   cfg_reg.backlight_on   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    i2lcd_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .cfg     (cfg_reg),
        .req     (req),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

endmodule

[src/i2lcd_seq.sv]
// Bus phase sequencer: one I2C phase per tick item, six writes per LCD byte.
// Depends on i2lcd_pkg and i2c_lcd_backpack_writer_defines.svh.
`include "i2c_lcd_backpack_writer_defines.svh"

module i2lcd_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  i2lcd_pkg::cfg_t   cfg,
    input  i2lcd_pkg::req_t   req,
    output i2lcd_pkg::res_t   res
);

    typedef enum logic [3:0] {
        PH_START     = 4'd0,
        PH_START_SCL = 4'd1,
        PH_BIT_SDA   = 4'd2,
        PH_BIT_SCLR  = 4'd3,
        PH_BIT_SCLL  = 4'd4,
        PH_ACK_REL   = 4'd5,
        PH_ACK_SAMP  = 4'd6,
        PH_ACK_SCLL  = 4'd7,
        PH_STOP_SDA  = 4'd8,
        PH_STOP_SCL  = 4'd9,
        PH_STOP_REL  = 4'd10
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] exp_idx_reg, exp_idx_next;
    logic [2:0] bit_idx_reg, bit_idx_next;
    logic       data_byte_reg, data_byte_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] held_value_reg, held_value_next;
    logic       held_mode_reg, held_mode_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       active_reg, active_next;
    logic       accepted, nack, done;

    always_comb begin
        phase_next      = phase_reg;
        exp_idx_next    = exp_idx_reg;
        bit_idx_next    = bit_idx_reg;
        data_byte_next  = data_byte_reg;
        shift_next      = shift_reg;
        held_value_next = held_value_reg;
        held_mode_next  = held_mode_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        active_next     = active_reg;
        accepted        = 1'b0;
        nack            = 1'b0;
        done            = 1'b0;

        if (req.req_type == i2lcd_pkg::REQ_SUBMIT) begin
            if (!active_reg) begin
                held_value_next = req.lcd_value;
                held_mode_next  = req.is_char;
                active_next     = 1'b1;
                phase_next      = PH_START;
                exp_idx_next    = 3'd0;
                bit_idx_next    = 3'd0;
                data_byte_next  = 1'b0;
                accepted        = 1'b1;
            end
        end else if (active_reg) begin
            unique case (phase_reg)
                PH_START: begin
                    sda_next       = 1'b1;
                    shift_next     = {cfg.device_address, 1'b0};
                    bit_idx_next   = 3'd0;
                    data_byte_next = 1'b0;
                    phase_next     = PH_START_SCL;
                end
                PH_START_SCL: begin
                    scl_next   = 1'b1;
                    phase_next = PH_BIT_SDA;
                end
                PH_BIT_SDA: begin
                    sda_next   = ~shift_reg[7];
                    shift_next = {shift_reg[6:0], 1'b0};
                    phase_next = PH_BIT_SCLR;
                end
                PH_BIT_SCLR: begin
                    scl_next   = 1'b0;
                    phase_next = PH_BIT_SCLL;
                end
                PH_BIT_SCLL: begin
                    scl_next = 1'b1;
                    if (bit_idx_reg == i2lcd_pkg::BIT_LAST) begin
                        bit_idx_next = 3'd0;
                        phase_next   = PH_ACK_REL;
                    end else begin
                        bit_idx_next = bit_idx_reg + 3'd1;
                        phase_next   = PH_BIT_SDA;
                    end
                end
                PH_ACK_REL: begin
                    sda_next   = 1'b0;
                    phase_next = PH_ACK_SAMP;
                end
                PH_ACK_SAMP: begin
                    scl_next   = 1'b0;
                    nack       = req.sda_in;
                    phase_next = PH_ACK_SCLL;
                end
                PH_ACK_SCLL: begin
                    scl_next = 1'b1;
                    if (!data_byte_reg) begin
                        data_byte_next = 1'b1;
                        shift_next     = i2lcd_pkg::expander_byte(held_value_reg,
                                             held_mode_reg, cfg.backlight_on, exp_idx_reg);
                        bit_idx_next   = 3'd0;
                        phase_next     = PH_BIT_SDA;
                    end else begin
                        phase_next = PH_STOP_SDA;
                    end
                end
                PH_STOP_SDA: begin
                    sda_next   = 1'b1;
                    phase_next = PH_STOP_SCL;
                end
                PH_STOP_SCL: begin
                    scl_next   = 1'b0;
                    phase_next = PH_STOP_REL;
                end
                PH_STOP_REL: begin
                    sda_next   = 1'b0;
                    phase_next = PH_START;
                    if (exp_idx_reg >= i2lcd_pkg::EXP_LAST) begin
                        exp_idx_next = 3'd0;
                        active_next  = 1'b0;
                        done         = 1'b1;
                    end else begin
                        exp_idx_next = exp_idx_reg + 3'd1;
                    end
                end
                default: begin
                    scl_next     = 1'b0;
                    sda_next     = 1'b0;
                    phase_next   = PH_START;
                    exp_idx_next = 3'd0;
                    active_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            exp_idx_reg    <= 3'd0;
            bit_idx_reg    <= 3'd0;
            data_byte_reg  <= 1'b0;
            shift_reg      <= 8'd0;
            held_value_reg <= 8'd0;
            held_mode_reg  <= 1'b0;
            scl_reg        <= 1'b0;
            sda_reg        <= 1'b0;
            active_reg     <= 1'b0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            exp_idx_reg    <= exp_idx_next;
            bit_idx_reg    <= bit_idx_next;
            data_byte_reg  <= data_byte_next;
            shift_reg      <= shift_next;
            held_value_reg <= held_value_next;
            held_mode_reg  <= held_mode_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            active_reg     <= active_next;
        end
    end

    assign res.scl_low  = scl_next;
    assign res.sda_low  = sda_next;
    assign res.busy_res = active_next;
    assign res.accepted = accepted;
    assign res.nack     = nack;
    assign res.done_res = done;

    // idle means both lines released
    `I2LCD_ASSERT_NOW(a_idle_released, aclk, aresetn, !active_reg, !scl_reg && !sda_reg)
    `I2LCD_ASSERT_NOW(a_nack_in_ack, aclk, aresetn, res.nack, phase_reg == PH_ACK_SAMP)
    `I2LCD_ASSERT_NOW(a_done_at_end, aclk, aresetn, res.done_res,
                      phase_reg == PH_STOP_REL && exp_idx_reg == i2lcd_pkg::EXP_LAST)
    `I2LCD_ASSERT_NEXT(a_submit_starts, aclk, aresetn, step_en && res.accepted,
                       active_reg && phase_reg == PH_START && exp_idx_reg == 3'd0)

endmodule

[tb/tb_i2c_lcd_backpack_writer.sv]
// Self-checking testbench for i2c_lcd_backpack_writer: drives submit and tick items,
// predicts the I2C drive levels and flags per item, and compares every result.
// Depends on i2lcd_pkg and the block's RTL only.
module tb_i2c_lcd_backpack_writer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PHASES   = 5;
    localparam int PHASE_REQS = 260;
    localparam int WATCHDOG   = 2000;
    localparam int IDLE_PCT   = 21;

    typedef enum logic [5:0] {
        PH_START, PH_ADDR_SCL, PH_BIT_SET, PH_BIT_RISE, PH_BIT_FALL,
        PH_ACK_FREE, PH_ACK_SAMPLE, PH_ACK_FALL, PH_STOP_SDA, PH_STOP_SCL,
        PH_STOP_FREE
    } bus_phase_t;

    class lcd_bus_scoreboard;
        logic [6:0]        dev_addr;
        logic              backlight;
        bus_phase_t        phase;
        logic [2:0]        exp_idx;
        logic [2:0]        bit_idx;
        logic              data_byte;
        logic [7:0]        shifter;
        logic [7:0]        value;
        logic              mode;
        logic              scl_lo;
        logic              sda_lo;
        logic              busy;
        i2lcd_pkg::res_t   levels_due[$];
        int                n_checked;
        int                n_errors;
        int                n_taken;
        int                n_refused;
        int                n_nacks;
        int                n_done;
        int                n_cfg;

        function new();
            dev_addr  = i2lcd_pkg::DEV_ADDR_RESET;
            backlight = i2lcd_pkg::BACKLIGHT_RESET;
            phase     = PH_START;
            exp_idx   = '0;
            bit_idx   = '0;
            data_byte = 1'b0;
            shifter   = '0;
            value     = '0;
            mode      = 1'b0;
            scl_lo    = 1'b0;
            sda_lo    = 1'b0;
            busy      = 1'b0;
        endfunction

        function void set_register(logic [1:0] idx, logic [6:0] data);
            n_cfg++;
            if (idx == i2lcd_pkg::CFG_IDX_ADDR) begin
                dev_addr = data;
            end else if (idx == i2lcd_pkg::CFG_IDX_BL) begin
                backlight = data[0];
            end
        endfunction

        // expander byte: nibble, backlight, enable, unused, register select
        function logic [7:0] nibble_frame();
            logic [3:0] nib;
            logic       strobe;
            nib    = (exp_idx < i2lcd_pkg::EXP_LO_FIRST) ? value[7:4] : value[3:0];
            strobe = (exp_idx == i2lcd_pkg::EXP_HI_EN) || (exp_idx == i2lcd_pkg::EXP_LO_EN);
            return {nib, backlight, strobe, 1'b0, mode};
        endfunction

        function void note_request(i2lcd_pkg::req_t r);
            i2lcd_pkg::res_t lv;
            lv = '0;
            if (r.req_type == i2lcd_pkg::REQ_SUBMIT) begin
                if (!busy) begin
                    value     = r.lcd_value;
                    mode      = r.is_char;
                    busy      = 1'b1;
                    phase     = PH_START;
                    exp_idx   = '0;
                    bit_idx   = '0;
                    data_byte = 1'b0;
                    lv.accepted = 1'b1;
                    n_taken++;
                end else begin
                    n_refused++;
                end
            end else if (busy) begin
                case (phase)
                    PH_START: begin
                        sda_lo    = 1'b1;
                        shifter   = {dev_addr, 1'b0};
                        bit_idx   = '0;
                        data_byte = 1'b0;
                        phase     = PH_ADDR_SCL;
                    end
                    PH_ADDR_SCL: begin
                        scl_lo = 1'b1;
                        phase  = PH_BIT_SET;
                    end
                    PH_BIT_SET: begin
                        sda_lo  = !shifter[7];
                        shifter = {shifter[6:0], 1'b0};
                        phase   = PH_BIT_RISE;
                    end
                    PH_BIT_RISE: begin
                        scl_lo = 1'b0;
                        phase  = PH_BIT_FALL;
                    end
                    PH_BIT_FALL: begin
                        scl_lo = 1'b1;
                        if (bit_idx == i2lcd_pkg::BIT_LAST) begin
                            bit_idx = '0;
                            phase   = PH_ACK_FREE;
                        end else begin
                            bit_idx++;
                            phase = PH_BIT_SET;
                        end
                    end
                    PH_ACK_FREE: begin
                        sda_lo = 1'b0;
                        phase  = PH_ACK_SAMPLE;
                    end
                    PH_ACK_SAMPLE: begin
                        scl_lo  = 1'b0;
                        lv.nack = r.sda_in;
                        phase   = PH_ACK_FALL;
                    end
                    PH_ACK_FALL: begin
                        scl_lo = 1'b1;
                        if (!data_byte) begin
                            data_byte = 1'b1;
                            shifter   = nibble_frame();
                            bit_idx   = '0;
                            phase     = PH_BIT_SET;
                        end else begin
                            phase = PH_STOP_SDA;
                        end
                    end
                    PH_STOP_SDA: begin
                        sda_lo = 1'b1;
                        phase  = PH_STOP_SCL;
                    end
                    PH_STOP_SCL: begin
                        scl_lo = 1'b0;
                        phase  = PH_STOP_FREE;
                    end
                    PH_STOP_FREE: begin
                        sda_lo = 1'b0;
                        phase  = PH_START;
                        if (exp_idx >= i2lcd_pkg::EXP_LAST) begin
                            exp_idx     = '0;
                            busy        = 1'b0;
                            lv.done_res = 1'b1;
                        end else begin
                            exp_idx++;
                        end
                    end
                    default: begin
                        scl_lo  = 1'b0;
                        sda_lo  = 1'b0;
                        phase   = PH_START;
                        exp_idx = '0;
                        busy    = 1'b0;
                    end
                endcase
            end
            lv.scl_low  = scl_lo;
            lv.sda_low  = sda_lo;
            lv.busy_res = busy;
            if (lv.nack) n_nacks++;
            if (lv.done_res) n_done++;
            levels_due.push_back(lv);
        endfunction

        function void compare_bit(string field, logic want, logic got);
            if (got !== want) begin
                n_errors++;
                $display("%0t: %s mismatch, expected %0b, actual %0b",
                         $time, field, want, got);
            end
        endfunction

        function void check_levels(i2lcd_pkg::res_t got);
            i2lcd_pkg::res_t want;
            if (levels_due.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual %06b", $time, got);
                return;
            end
            want = levels_due.pop_front();
            n_checked++;
            compare_bit("scl_low", want.scl_low, got.scl_low);
            compare_bit("sda_low", want.sda_low, got.sda_low);
            compare_bit("busy_res", want.busy_res, got.busy_res);
            compare_bit("accepted", want.accepted, got.accepted);
            compare_bit("nack", want.nack, got.nack);
            compare_bit("done_res", want.done_res, got.done_res);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    lcd_bus_scoreboard sb = new();

    i2c_lcd_backpack_writer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // result side: random back-pressure, one long hold-off, one stretch always ready
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_levels(i2lcd_pkg::res_t'(m_tdata[5:0]));
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && sb.n_checked == 400) begin
                hold_done = 1;
                hold_left = 80;
                m_tready <= 1'b0;
            end else if (sb.n_checked >= 700 && sb.n_checked < 950) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_request(input i2lcd_pkg::req_t r, input bit may_idle);
        if (may_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.sda_in, r.lcd_value};
        s_tuser  <= {r.is_char, r.req_type};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    // leaves cfg_valid high so back-to-back writes never drop it within a step
    task automatic write_register(input logic [1:0] idx, input logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, data);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.levels_due.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic program_settings(input logic [6:0] addr, input logic bl);
        write_register(i2lcd_pkg::CFG_IDX_ADDR, addr);
        write_register(i2lcd_pkg::CFG_IDX_BL, {6'd0, bl});
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        i2lcd_pkg::req_t r;
        int              seq_no;
        int              n_live;
        logic [7:0]      last_value;
        logic [6:0]      addr;
        logic            bl;

        seq_no     = 0;
        last_value = '0;
        @(posedge aresetn);
        @(posedge aclk);
        program_settings(7'h3c, 1'b1);

        // directed: idle ticks, submit, refused submit, first phases of the start
        r = '{req_type: i2lcd_pkg::REQ_TICK, lcd_value: 8'h00, is_char: 1'b0,
              sda_in: 1'b0};
        send_request(r, 1'b0);
        r = '{req_type: i2lcd_pkg::REQ_TICK, lcd_value: 8'hff, is_char: 1'b1,
              sda_in: 1'b1};
        send_request(r, 1'b0);
        r = '{req_type: i2lcd_pkg::REQ_SUBMIT, lcd_value: 8'hff, is_char: 1'b1,
              sda_in: 1'b0};
        send_request(r, 1'b0);
        r = '{req_type: i2lcd_pkg::REQ_SUBMIT, lcd_value: 8'h00, is_char: 1'b0,
              sda_in: 1'b1};
        send_request(r, 1'b0);
        for (int i = 0; i < 12; i++) begin
            r = '{req_type: i2lcd_pkg::REQ_TICK, lcd_value: 8'(i), is_char: i[0],
                  sda_in: i[1]};
            send_request(r, 1'b1);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            case (p)
                0: begin addr = 7'h00; bl = 1'b0; end
                1: begin addr = 7'h7f; bl = 1'b1; end
                2: begin addr = 7'($urandom); bl = 1'b0; end
                default: begin addr = 7'($urandom); bl = 1'($urandom); end
            endcase
            program_settings(addr, bl);
            n_live = 0;
            while (n_live < PHASE_REQS) begin
                r.lcd_value = 8'($urandom);
                r.is_char   = 1'($urandom);
                r.sda_in    = ($urandom_range(99) < 20);
                if (!sb.busy) begin
                    if ($urandom_range(99) < 85) begin
                        r.req_type = i2lcd_pkg::REQ_SUBMIT;
                        if (seq_no == 0)
                            r.lcd_value = 8'h00;
                        else if (seq_no[0])
                            r.lcd_value = 8'($urandom);
                        else
                            r.lcd_value = ~last_value;
                        r.is_char  = seq_no[0];
                        last_value = r.lcd_value;
                        seq_no++;
                        n_live++;
                    end else begin
                        r.req_type = i2lcd_pkg::REQ_TICK;
                    end
                end else if ($urandom_range(99) < 4) begin
                    r.req_type = i2lcd_pkg::REQ_SUBMIT;
                end else begin
                    r.req_type = i2lcd_pkg::REQ_TICK;
                    n_live++;
                end
                send_request(r, p != 2);
            end
        end

        drain_results();
        repeat (4) @(posedge aclk);
        $display("Covered %0d results: %0d bytes taken, %0d refused, %0d sequences done.",
                 sb.n_checked, sb.n_taken, sb.n_refused, sb.n_done);
        $display("%0d NACK samples, %0d register writes.", sb.n_nacks, sb.n_cfg);
        if (sb.n_errors == 0 && sb.levels_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[i2c_lcd_backpack_writer.f]
+incdir+src
src/i2lcd_pkg.sv
src/i2lcd_seq.sv
src/i2c_lcd_backpack_writer.sv
tb/tb_i2c_lcd_backpack_writer.sv
